@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the framer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/fpcf_pkg.sv @@
// ---------------------------------------------------------------------------
// fpcf_pkg
// Types and constants shared by the fast-packet framer modules.
// ---------------------------------------------------------------------------
package fpcf_pkg;

	localparam int unsigned GRP_W   = 18;
	localparam int unsigned SEQ_W   = 3;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned LEFT_W  = 4;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned PRIO_W  = 3;
	localparam int unsigned ADDR8_W = 8;

	localparam logic [7:0]        PAD_BYTE   = 8'hFF;
	localparam logic [PRIO_W-1:0] PRIO_RST   = 3'd2;
	localparam logic [7:0]        SRC_RST    = 8'd254;
	// bytes in a single frame, in the first frame, and in a later frame
	localparam logic [LEFT_W-1:0] SINGLE_MAX = 4'd8;
	localparam logic [LEFT_W-1:0] FIRST_CNT  = 4'd6;
	localparam logic [LEFT_W-1:0] LATER_CNT  = 4'd7;
	localparam logic [SLOT_W-1:0] FIRST_SLOT = 3'd2;
	localparam logic [SLOT_W-1:0] LATER_SLOT = 3'd1;

	// configuration register indexes
	localparam logic REG_PRIO = 1'b0;
	localparam logic REG_SRC  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_FILL  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic start_frame;
		logic fill;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic fill_done;
		logic frame_last;
	} sts_t;

endpackage

@@ rtl/core/fpcf_if.sv @@
// ---------------------------------------------------------------------------
// fpcf_if
// Valid/ready channels: payload bytes in, CAN frames out.
// ---------------------------------------------------------------------------
interface fpcf_msg_if;
	logic                       valid;
	logic                       ready;
	logic [7:0]                 payload_byte;
	logic [fpcf_pkg::GRP_W-1:0] group_number;
	logic                       last_byte;

	modport source (output valid, payload_byte, group_number, last_byte, input ready);
	modport sink   (input valid, payload_byte, group_number, last_byte, output ready);
endinterface

interface fpcf_frame_if;
	logic                        valid;
	logic                        ready;
	logic [fpcf_pkg::GRP_W-1:0]  frame_group_number;
	logic [fpcf_pkg::PRIO_W-1:0] frame_prio;
	logic [7:0]                  frame_source;
	logic [7:0]                  pdu_format;
	logic [7:0]                  pdu_specific;
	logic [fpcf_pkg::DATA_W-1:0] frame_bytes;
	logic                        last_frame;

	modport source (output valid, frame_group_number, frame_prio, frame_source,
		pdu_format, pdu_specific, frame_bytes, last_frame, input ready);
	modport sink   (input valid, frame_group_number, frame_prio, frame_source,
		pdu_format, pdu_specific, frame_bytes, last_frame, output ready);
endinterface

@@ rtl/core/fpcf_ram.sv @@
// ---------------------------------------------------------------------------
// fpcf_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fpcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 223
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/fpcf_ctrl.sv @@
// ---------------------------------------------------------------------------
// fpcf_ctrl
// Sequencer: take bytes, then build and hand out frames one by one.
// ---------------------------------------------------------------------------
module fpcf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_ready,
	output logic           frame_valid,
	input  logic           frame_ready,
	input  fpcf_pkg::sts_t sts,
	output fpcf_pkg::cmd_t cmd
);

	fpcf_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign msg_ready       = (state_q == fpcf_pkg::ST_IDLE);
	assign frame_valid     = (state_q == fpcf_pkg::ST_EMIT);
	assign cmd.take        = msg_valid && msg_ready;
	assign cmd.start_frame = (state_q == fpcf_pkg::ST_START);
	assign cmd.fill        = (state_q == fpcf_pkg::ST_FILL);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpcf_pkg::ST_IDLE: begin
				if (cmd.take && sts.go) begin
					state_nxt = fpcf_pkg::ST_START;
				end
			end
			fpcf_pkg::ST_START: begin
				state_nxt = fpcf_pkg::ST_FILL;
			end
			fpcf_pkg::ST_FILL: begin
				if (sts.fill_done) begin
					state_nxt = fpcf_pkg::ST_EMIT;
				end
			end
			fpcf_pkg::ST_EMIT: begin
				if (frame_ready) begin
					state_nxt = sts.frame_last ? fpcf_pkg::ST_IDLE : fpcf_pkg::ST_START;
				end
			end
			default: begin
				state_nxt = fpcf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/fpcf_dpath.sv @@
// ---------------------------------------------------------------------------
// fpcf_dpath
// Byte buffer, message bookkeeping and frame assembly register.
// ---------------------------------------------------------------------------
module fpcf_dpath #(
	parameter int unsigned MAX_PAYLOAD = 223
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fpcf_pkg::cmd_t              cmd,
	output fpcf_pkg::sts_t              sts,
	input  logic [7:0]                  payload_byte,
	input  logic [fpcf_pkg::GRP_W-1:0]  group_number,
	input  logic                        last_byte,
	output logic [fpcf_pkg::GRP_W-1:0]  frame_group_number,
	output logic [7:0]                  pdu_format,
	output logic [7:0]                  pdu_specific,
	output logic [fpcf_pkg::DATA_W-1:0] frame_bytes,
	output logic                        last_frame
);

	localparam int unsigned AW    = $clog2(MAX_PAYLOAD);
	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

	// control state
	logic [CNT_W-1:0]            count_q;
	logic                        too_long_q;
	logic [fpcf_pkg::SEQ_W-1:0]  seq_q;
	logic [fpcf_pkg::LEFT_W-1:0] left_q;
	logic                        pend_s1;
	// payload / message context
	logic [CNT_W-1:0]            n_q;
	logic [CNT_W-1:0]            rd_ptr_q;
	logic [fpcf_pkg::IDX_W-1:0]  idx_q;
	logic [fpcf_pkg::SEQ_W-1:0]  msg_seq_q;
	logic [fpcf_pkg::SLOT_W-1:0] slot_q;
	logic [fpcf_pkg::SLOT_W-1:0] pend_slot_s1;
	logic [fpcf_pkg::GRP_W-1:0]  grp_q;
	logic [fpcf_pkg::DATA_W-1:0] frame_q;
	logic                        last_q;

	logic                        store;
	logic                        tl_nxt;
	logic [CNT_W-1:0]            cnt_nxt;
	logic                        multi;
	logic [CNT_W-1:0]            rem;
	logic                        issue;
	logic [7:0]                  ram_rdata;
	// frame setup
	logic [fpcf_pkg::DATA_W-1:0] hdr_frame;
	logic [fpcf_pkg::SLOT_W-1:0] hdr_slot;
	logic [fpcf_pkg::LEFT_W-1:0] hdr_left;
	logic                        hdr_last;

	assign store   = !too_long_q && (count_q < CNT_W'(MAX_PAYLOAD));
	assign tl_nxt  = too_long_q || !store;
	assign cnt_nxt = count_q + CNT_W'(store);
	assign sts.go  = cmd.take && last_byte && !tl_nxt;

	assign multi = (n_q > CNT_W'(fpcf_pkg::SINGLE_MAX));
	assign rem   = n_q - rd_ptr_q;
	assign issue = cmd.fill && (left_q != '0);

	always_comb begin
		hdr_frame = '1;
		hdr_slot  = '0;
		hdr_left  = fpcf_pkg::LEFT_W'(n_q);
		hdr_last  = 1'b1;
		if (multi) begin
			if (idx_q == '0) begin
				hdr_frame[7:0]  = {msg_seq_q, fpcf_pkg::IDX_W'(0)};
				hdr_frame[15:8] = 8'(n_q);
				hdr_slot        = fpcf_pkg::FIRST_SLOT;
				hdr_left        = fpcf_pkg::FIRST_CNT;
				hdr_last        = 1'b0;
			end else begin
				hdr_frame[7:0] = {msg_seq_q, idx_q};
				hdr_slot       = fpcf_pkg::LATER_SLOT;
				hdr_last       = (rem <= CNT_W'(fpcf_pkg::LATER_CNT));
				hdr_left       = hdr_last ? fpcf_pkg::LEFT_W'(rem) : fpcf_pkg::LATER_CNT;
			end
		end
	end

	fpcf_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_buf (
		.clk   (clk),
		.we    (cmd.take && store),
		.waddr (count_q[AW-1:0]),
		.wdata (payload_byte),
		.re    (issue),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			too_long_q <= 1'b0;
			seq_q      <= '0;
			left_q     <= '0;
			pend_s1    <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (last_byte) begin
					count_q    <= '0;
					too_long_q <= 1'b0;
					if (sts.go && (cnt_nxt > CNT_W'(fpcf_pkg::SINGLE_MAX))) begin
						seq_q <= seq_q + 1'b1;
					end
				end else begin
					count_q    <= cnt_nxt;
					too_long_q <= tl_nxt;
				end
			end
			if (cmd.start_frame) begin
				left_q <= hdr_left;
			end else if (issue) begin
				left_q <= left_q - 1'b1;
			end
			pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.go) begin
			n_q       <= cnt_nxt;
			grp_q     <= group_number;
			rd_ptr_q  <= '0;
			idx_q     <= '0;
			msg_seq_q <= seq_q;
		end
		if (cmd.start_frame) begin
			frame_q <= hdr_frame;
			slot_q  <= hdr_slot;
			last_q  <= hdr_last;
			idx_q   <= idx_q + 1'b1;
		end
		if (issue) begin
			rd_ptr_q     <= rd_ptr_q + 1'b1;
			slot_q       <= slot_q + 1'b1;
			pend_slot_s1 <= slot_q;
		end
		if (pend_s1) begin
			frame_q[pend_slot_s1*8 +: 8] <= ram_rdata;
		end
	end

	assign sts.fill_done  = (left_q == '0) && !pend_s1;
	assign sts.frame_last = last_q;

	assign frame_group_number = grp_q;
	assign pdu_format         = grp_q[15:8];
	assign pdu_specific       = grp_q[7:0];
	assign frame_bytes        = frame_q;
	assign last_frame         = last_q;

endmodule

@@ rtl/core/fast_packet_can_framer.sv @@
// ---------------------------------------------------------------------------
// fast_packet_can_framer
// Buffers message bytes and sends them as fast-packet CAN frames.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      transaction
//  msg      in   valid/ready    one payload byte + group number + last flag
//  frame    out  valid/ready    one 8-byte CAN frame with header fields
//  apb      in   psel/penable   write/read of frame_priority, source_address
//
//  A byte is taken and written into the buffer RAM while the message fits.
//  On an accepted last byte of a message that fits, the block stops taking
//  bytes and builds frames: per frame a setup state, a fill state (one RAM
//  read per byte, the registered read data written in, and the done flag),
//  then the frame is on offer, held until taken.
//  Reset is asynchronous; the buffer needs no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_packet_can_framer #(
	parameter int unsigned MAX_PAYLOAD = 223
) (
	input  logic                clk,
	input  logic                arst_n,
	fpcf_msg_if.sink            msg,
	fpcf_frame_if.source        frame,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [fpcf_pkg::PRIO_W-1:0] prio_q;
	logic [7:0]                  src_q;
	logic                        reg_sel;
	logic                        cfg_wr;
	fpcf_pkg::cmd_t              cmd;
	fpcf_pkg::sts_t              sts;

	// ---- configuration registers (4-byte stride) ----
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= fpcf_pkg::PRIO_RST;
			src_q  <= fpcf_pkg::SRC_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				fpcf_pkg::REG_PRIO: prio_q <= pwdata[fpcf_pkg::PRIO_W-1:0];
				fpcf_pkg::REG_SRC:  src_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			fpcf_pkg::REG_PRIO: prdata = {29'd0, prio_q};
			fpcf_pkg::REG_SRC:  prdata = {24'd0, src_q};
			default:            prdata = '0;
		endcase
	end

	// ---- sequencer ----
	fpcf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg.valid),
		.msg_ready   (msg.ready),
		.frame_valid (frame.valid),
		.frame_ready (frame.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// ---- buffer and frame assembly ----
	fpcf_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.payload_byte       (msg.payload_byte),
		.group_number       (msg.group_number),
		.last_byte          (msg.last_byte),
		.frame_group_number (frame.frame_group_number),
		.pdu_format         (frame.pdu_format),
		.pdu_specific       (frame.pdu_specific),
		.frame_bytes        (frame.frame_bytes),
		.last_frame         (frame.last_frame)
	);

	// header fields from config; user changes it only while idle, unchecked
	assign frame.frame_prio   = prio_q;
	assign frame.frame_source = src_q;

	// ---- checks ----
	// one message in flight: no byte taken while a frame is on offer
	`ASSERT_IMPLIES(a_no_take_while_emit, clk, arst_n, frame.valid, !msg.ready)
	// after the final frame goes out the block is ready for the next message
	`ASSERT_NEXT(a_ready_after_last, clk, arst_n,
		frame.valid && frame.ready && frame.last_frame, msg.ready)
	// a message that will produce frames closes the input next cycle
	`ASSERT_NEXT(a_busy_after_go, clk, arst_n, sts.go, !msg.ready && !frame.valid)

endmodule
